// ----- sv/dht_pkg.sv -----
package dht_pkg;

    localparam int TABLE_SIZE_DEF   = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int KEY_W         = 31;
    localparam int PAY_FIELD_W   = 32;
    localparam int SLOT_FIELD_W  = 4;
    localparam int PROBE_FIELD_W = 5;
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    localparam int STEP_PRIME = 7;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [PAY_FIELD_W-1:0]   payload;
        logic [PROBE_FIELD_W-1:0] probes;
        logic [SLOT_FIELD_W-1:0]  slot;
    } res_t;

endpackage

// ----- sv/dht_hash.sv -----
module dht_hash #(
    parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF,
    parameter int IDX_W      = $clog2(dht_pkg::TABLE_SIZE_DEF)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [dht_pkg::KEY_W-1:0] key,
    output logic                     done,
    output logic [IDX_W-1:0]         h1,
    output logic [IDX_W-1:0]         h2m
);

    localparam int KW     = dht_pkg::KEY_W;
    localparam int RCP_W  = 32;
    localparam int PROD_W = KW + RCP_W;
    localparam int SH_N   = KW + $clog2(TABLE_SIZE);
    localparam int SH_P   = KW + $clog2(dht_pkg::STEP_PRIME);
    localparam int H_W    = (IDX_W + 1 > 4) ? IDX_W + 1 : 4;
    localparam logic [RCP_W-1:0] RCP_N = RCP_W'(((64'd1 << SH_N)
                                                + 64'(TABLE_SIZE) - 64'd1)
                                                / 64'(TABLE_SIZE));
    localparam logic [RCP_W-1:0] RCP_P = RCP_W'(((64'd1 << SH_P)
                                                + 64'(dht_pkg::STEP_PRIME) - 64'd1)
                                                / 64'(dht_pkg::STEP_PRIME));
    localparam logic [KW-1:0]    N_K = KW'(TABLE_SIZE);
    localparam logic [KW-1:0]    P_K = KW'(dht_pkg::STEP_PRIME);
    localparam logic [H_W-1:0]   N_H = H_W'(TABLE_SIZE);

    logic [KW-1:0]     key_reg;
    logic [KW-1:0]     qn_reg, qn_next;
    logic [KW-1:0]     qp_reg, qp_next;
    logic [IDX_W-1:0]  r1_reg, r1_next;
    logic [2:0]        r7_reg, r7_next;
    logic              st1_reg;
    logic              st2_reg;
    logic              done_reg;
    logic [PROD_W-1:0] prod_n;
    logic [PROD_W-1:0] prod_p;
    logic [KW-1:0]     rem_n;
    logic [KW-1:0]     rem_p;
    logic [H_W-1:0]    v;

    // key mod N and key mod 7 by reciprocal multiplication, exact for 31-bit keys
    assign prod_n  = PROD_W'(key_reg) * PROD_W'(RCP_N);
    assign prod_p  = PROD_W'(key_reg) * PROD_W'(RCP_P);
    assign qn_next = KW'(prod_n >> SH_N);
    assign qp_next = KW'(prod_p >> SH_P);
    assign rem_n   = key_reg - qn_reg * N_K;
    assign rem_p   = key_reg - qp_reg * P_K;
    assign r1_next = rem_n[IDX_W-1:0];
    assign r7_next = rem_p[2:0];

    // step size reduced mod N
    always_comb begin
        v = H_W'(dht_pkg::STEP_PRIME) - H_W'(r7_reg);
        for (int i = 0; i < 3; i++) begin
            if (v >= N_H) begin
                v = v - N_H;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg  <= 1'b0;
            st2_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            st1_reg  <= start;
            st2_reg  <= st1_reg;
            done_reg <= st2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg <= key;
        end
        qn_reg <= qn_next;
        qp_reg <= qp_next;
        r1_reg <= r1_next;
        r7_reg <= r7_next;
    end

    assign done = done_reg;
    assign h1   = r1_reg;
    assign h2m  = v[IDX_W-1:0];

endmodule

// ----- sv/dht_mem.sv -----
module dht_mem #(
    parameter int DEPTH  = dht_pkg::TABLE_SIZE_DEF,
    parameter int ADDR_W = $clog2(dht_pkg::TABLE_SIZE_DEF),
    parameter int DATA_W = 1 + dht_pkg::KEY_W + dht_pkg::PAYLOAD_BITS_DEF
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/dht_ctrl.sv -----
module dht_ctrl #(
    parameter int TABLE_SIZE   = dht_pkg::TABLE_SIZE_DEF,
    parameter int PAYLOAD_BITS = dht_pkg::PAYLOAD_BITS_DEF,
    parameter int IDX_W        = $clog2(dht_pkg::TABLE_SIZE_DEF),
    parameter int CNT_W        = $clog2(dht_pkg::TABLE_SIZE_DEF + 1),
    parameter int WORD_W       = 1 + dht_pkg::KEY_W + dht_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dht_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [dht_pkg::ACTION_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dht_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [dht_pkg::STATUS_W-1:0]  m_tuser,
    output logic                          hash_start,
    output logic [dht_pkg::KEY_W-1:0]     hash_key,
    input  logic                          hash_done,
    input  logic [IDX_W-1:0]              hash_h1,
    input  logic [IDX_W-1:0]              hash_h2m,
    output logic                          mem_we,
    output logic [IDX_W-1:0]              mem_waddr,
    output logic [WORD_W-1:0]             mem_wdata,
    output logic [IDX_W-1:0]              mem_raddr,
    input  logic [WORD_W-1:0]             mem_rdata
);

    localparam int KW = dht_pkg::KEY_W;
    localparam int PW = dht_pkg::PAY_FIELD_W;
    localparam logic [IDX_W:0]   N_C      = (IDX_W + 1)'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    dht_pkg::state_t state_reg, state_next;

    logic [dht_pkg::ACTION_W-1:0] act_reg;
    logic [KW-1:0]                key_reg;
    logic [PAYLOAD_BITS-1:0]      pay_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [IDX_W-1:0]             h2m_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [IDX_W-1:0]             clr_reg;
    dht_pkg::res_t                res_reg, res_next;
    dht_pkg::res_t                out_reg;
    logic                         m_valid_reg;

    logic                         s_accept;
    logic                         out_free;
    logic                         finish;
    logic                         p_used;
    logic                         p_hit;
    logic [KW-1:0]                p_key;
    logic [PAYLOAD_BITS-1:0]      p_pay;
    logic                         cnt_last_ins;
    logic                         cnt_last;
    logic [IDX_W:0]               idx_sum;
    logic [IDX_W-1:0]             idx_step;
    logic [PAYLOAD_BITS+PW-1:0]   in_pay_ext;
    logic [PAYLOAD_BITS+PW-1:0]   out_pay_ext;
    logic [IDX_W+dht_pkg::SLOT_FIELD_W-1:0]  slot_ext;
    logic [CNT_W+dht_pkg::PROBE_FIELD_W-1:0] probes_ext;

    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign in_pay_ext = {PAYLOAD_BITS'(0), s_tdata[KW +: PW]};

    assign p_used = mem_rdata[WORD_W-1];
    assign p_key  = mem_rdata[WORD_W-2 -: KW];
    assign p_pay  = mem_rdata[PAYLOAD_BITS-1:0];
    assign p_hit  = p_used && (p_key == key_reg);

    assign cnt_last_ins = cnt_reg >= CNT_W'(TABLE_SIZE - 1);
    assign cnt_last     = cnt_reg >= CNT_W'(TABLE_SIZE);

    assign idx_sum  = {1'b0, idx_reg} + {1'b0, h2m_reg};
    assign idx_step = (idx_sum >= N_C) ? IDX_W'(idx_sum - N_C) : idx_sum[IDX_W-1:0];

    assign out_pay_ext = {PW'(0), p_pay};
    assign slot_ext    = {dht_pkg::SLOT_FIELD_W'(0), idx_reg};
    assign probes_ext  = {dht_pkg::PROBE_FIELD_W'(0), cnt_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dht_pkg::ST_CLEAR: begin
                if (clr_reg == LAST_IDX) begin
                    state_next = dht_pkg::ST_IDLE;
                end
            end
            dht_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = dht_pkg::ST_HASH;
                end
            end
            dht_pkg::ST_HASH: begin
                if (hash_done) begin
                    state_next = dht_pkg::ST_PROBE;
                end
            end
            dht_pkg::ST_PROBE: begin
                if (finish) begin
                    state_next = dht_pkg::ST_RESP;
                end
            end
            dht_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = dht_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dht_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        hash_start = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = '0;
        mem_raddr  = idx_reg;
        finish     = 1'b0;
        res_next   = '0;
        unique case (state_reg)
            dht_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            dht_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                hash_start = s_tvalid;
            end
            dht_pkg::ST_HASH: begin
                mem_raddr = hash_h1;
            end
            dht_pkg::ST_PROBE: begin
                res_next.probes = probes_ext[dht_pkg::PROBE_FIELD_W-1:0];
                if (act_reg == dht_pkg::ACT_INSERT) begin
                    priority if (!p_used) begin
                        finish          = 1'b1;
                        mem_we          = 1'b1;
                        mem_wdata       = {1'b1, key_reg, pay_reg};
                        res_next.status = dht_pkg::STATUS_OK;
                        res_next.slot   = slot_ext[dht_pkg::SLOT_FIELD_W-1:0];
                    end else if (cnt_last_ins) begin
                        finish          = 1'b1;
                        res_next.status = dht_pkg::STATUS_FULL;
                    end else begin
                        mem_raddr = idx_step;
                    end
                end else begin
                    priority if (!p_used) begin
                        finish          = 1'b1;
                        res_next.status = dht_pkg::STATUS_NOT_FOUND;
                    end else if (p_hit) begin
                        finish           = 1'b1;
                        res_next.status  = dht_pkg::STATUS_OK;
                        res_next.slot    = slot_ext[dht_pkg::SLOT_FIELD_W-1:0];
                        res_next.payload = out_pay_ext[PW-1:0];
                        if (act_reg == dht_pkg::ACT_DELETE) begin
                            mem_we    = 1'b1;
                            mem_wdata = {1'b0, mem_rdata[WORD_W-2:0]};
                        end
                    end else if (cnt_last) begin
                        finish          = 1'b1;
                        res_next.status = dht_pkg::STATUS_NOT_FOUND;
                    end else begin
                        mem_raddr = idx_step;
                    end
                end
            end
            dht_pkg::ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dht_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == dht_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == dht_pkg::ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg <= s_tuser;
            key_reg <= s_tdata[KW-1:0];
            pay_reg <= in_pay_ext[PAYLOAD_BITS-1:0];
        end
        if (state_reg == dht_pkg::ST_HASH && hash_done) begin
            idx_reg <= hash_h1;
            h2m_reg <= hash_h2m;
            cnt_reg <= CNT_W'(1);
        end
        if (state_reg == dht_pkg::ST_PROBE) begin
            if (finish) begin
                res_reg <= res_next;
            end else begin
                idx_reg <= idx_step;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (state_reg == dht_pkg::ST_RESP && out_free) begin
            out_reg <= res_reg;
        end
    end

    assign hash_key = s_tdata[KW-1:0];
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = dht_pkg::M_TDATA_W'({out_reg.payload, out_reg.probes, out_reg.slot});

`ifndef SYNTH
    a_write_ends_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dht_pkg::ST_PROBE && mem_we) |=> (state_reg == dht_pkg::ST_RESP))
        else $error("table write did not end the operation");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dht_pkg::ST_PROBE) |->
        (cnt_reg >= CNT_W'(1) && cnt_reg <= CNT_W'(TABLE_SIZE)))
        else $error("probe count out of range");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dht_pkg::ST_PROBE) |-> ({1'b0, idx_reg} < N_C))
        else $error("probe index beyond table");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == dht_pkg::ST_RESP))
        else $error("result raised outside the response state");
`endif

endmodule

// ----- sv/double_hash_table_engine.sv -----
// channel   dir  tdata (lsb up)                                   tuser
// s_        in   key[30:0], payload[62:31], zero[63]              action[1:0]
// m_        out  slot[3:0], probes[8:4], found_payload[40:9], 0s  status[1:0]
//
// an item passes from accept through the reciprocal-multiply hash unit, one table read per probe
// (probes 1..TABLE_SIZE) and a response state before the engine returns to idle
// after reset a clearing pass writes every table slot while s_tready is low
// a finished result waits in the output register while the next item is taken;
// a further result holds the engine until the first one is taken
module double_hash_table_engine #(
    parameter int TABLE_SIZE   = dht_pkg::TABLE_SIZE_DEF,
    parameter int PAYLOAD_BITS = dht_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dht_pkg::S_TDATA_W-1:0] s_tdata,   // key, payload
    input  logic [dht_pkg::ACTION_W-1:0]  s_tuser,   // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dht_pkg::M_TDATA_W-1:0] m_tdata,   // slot, probes, found_payload
    output logic [dht_pkg::STATUS_W-1:0]  m_tuser    // status
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
    localparam int WORD_W = 1 + dht_pkg::KEY_W + PAYLOAD_BITS;

    logic                      hash_start;
    logic [dht_pkg::KEY_W-1:0] hash_key;
    logic                      hash_done;
    logic [IDX_W-1:0]          hash_h1;
    logic [IDX_W-1:0]          hash_h2m;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [WORD_W-1:0]         mem_wdata;
    logic [IDX_W-1:0]          mem_raddr;
    logic [WORD_W-1:0]         mem_rdata;

    dht_hash #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (hash_key),
        .done    (hash_done),
        .h1      (hash_h1),
        .h2m     (hash_h2m)
    );

    dht_mem #(
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (IDX_W),
        .DATA_W (WORD_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dht_ctrl #(
        .TABLE_SIZE   (TABLE_SIZE),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W),
        .WORD_W       (WORD_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .hash_start (hash_start),
        .hash_key   (hash_key),
        .hash_done  (hash_done),
        .hash_h1    (hash_h1),
        .hash_h2m   (hash_h2m),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

endmodule

// ----- test/tb_double_hash_table_engine.sv -----
`timescale 1ns / 1ps

module tb_double_hash_table_engine;
    import dht_pkg::*;

    localparam int N           = TABLE_SIZE_DEF;
    localparam int N_ROWS      = 15;
    localparam int POOL_N      = 24;
    localparam int ITEM_GOAL   = 1700;
    localparam int HOLD_CYCLES = 300;

    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam logic [KEY_W-1:0]    FILL_BASE = 31'h7FFF_FF00;

    typedef struct {
        logic [ACTION_W-1:0]    act;
        logic [KEY_W-1:0]       key;
        int                     reps;
        logic [PAY_FIELD_W-1:0] pay;
        bit                     typed;
        res_t                   want;
    } op_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [ACTION_W-1:0]    s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    op_row_t                op_tab [N_ROWS];
    res_t                   result_q [$];
    bit                     tbl_used [N];
    logic [KEY_W-1:0]       tbl_key [N];
    logic [PAY_FIELD_W-1:0] tbl_pay [N];
    logic [KEY_W-1:0]       key_pool [POOL_N];
    int                     mism_cnt;
    int                     items_sent;
    bit                     tx_idle_en = 1'b1;
    bit                     rx_idle_en = 1'b1;
    bit                     stall_req;
    res_t                   want_r;
    res_t                   got_r;

    double_hash_table_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned probe_at(logic [KEY_W-1:0] key, int unsigned d);
        int unsigned k;
        int unsigned h1;
        int unsigned h2;
        k  = key;
        h1 = k % N;
        h2 = STEP_PRIME - (k % STEP_PRIME);
        return (h1 + d * h2) % N;
    endfunction

    function automatic res_t apply_table_op(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] key,
                                            logic [PAY_FIELD_W-1:0] pay);
        res_t        r;
        int unsigned idx;
        int unsigned cnt;
        bit          done;
        r    = '0;
        idx  = probe_at(key, 0);
        cnt  = 1;
        done = 1'b0;
        if (act == ACT_INSERT) begin
            while (!done && tbl_used[idx]) begin
                idx = probe_at(key, cnt);
                cnt++;
                if (cnt >= N) done = 1'b1;
            end
            if (done) begin
                r.status = STATUS_FULL;
                r.probes = PROBE_FIELD_W'(N - 1);
            end else begin
                tbl_used[idx] = 1'b1;
                tbl_key[idx]  = key;
                tbl_pay[idx]  = pay;
                r.status      = STATUS_OK;
                r.slot        = SLOT_FIELD_W'(idx);
                r.probes      = PROBE_FIELD_W'(cnt);
            end
        end else begin
            // find, spare code and delete share one search
            while (!done) begin
                if (!tbl_used[idx]) begin
                    r.status = STATUS_NOT_FOUND;
                    r.probes = PROBE_FIELD_W'(cnt);
                    done     = 1'b1;
                end else if (tbl_key[idx] == key) begin
                    r.status  = STATUS_OK;
                    r.slot    = SLOT_FIELD_W'(idx);
                    r.probes  = PROBE_FIELD_W'(cnt);
                    r.payload = tbl_pay[idx];
                    if (act == ACT_DELETE) tbl_used[idx] = 1'b0;
                    done = 1'b1;
                end else if (cnt >= N) begin
                    r.status = STATUS_NOT_FOUND;
                    r.probes = PROBE_FIELD_W'(cnt);
                    done     = 1'b1;
                end else begin
                    idx = probe_at(key, cnt);
                    cnt++;
                end
            end
        end
        return r;
    endfunction

    function automatic int unsigned count_used();
        int unsigned n;
        n = 0;
        for (int i = 0; i < N; i++) n += tbl_used[i];
        return n;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(3))
            0, 1: return key_pool[$urandom_range(POOL_N - 1)];
            2: return KEY_W'($urandom());
            default: return KEY_W'($urandom_range(63));
        endcase
    endfunction

    task automatic send_op(output res_t r, input logic [ACTION_W-1:0] act,
                           input logic [KEY_W-1:0] key, input logic [PAY_FIELD_W-1:0] pay,
                           input bit typed = 1'b0, input res_t want = '0);
        @(negedge aclk);
        while (tx_idle_en && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pay, key};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        r = apply_table_op(act, key, pay);
        result_q.push_back(typed ? want : r);
        items_sent++;
    endtask

    task automatic send_lookup(input logic [KEY_W-1:0] live [$]);
        res_t        r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (live.size() != 0 && pick < 50)
            send_op(r, ACT_FIND, live[$urandom_range(live.size() - 1)], $urandom());
        else if (live.size() != 0 && pick < 65)
            send_op(r, ACT_SPARE, live[$urandom_range(live.size() - 1)], $urandom());
        else if (pick < 85)
            send_op(r, ACT_FIND, pick_key(), $urandom());
        else
            send_op(r, ACTION_W'($urandom_range(3)), pick_key(), $urandom());
    endtask

    // empties the table; entries cut off from their chain are reached by
    // plugging the holes with keys that hash straight to them
    task automatic drain_table();
        res_t             r;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] fills [$];
        int unsigned      s;
        int unsigned      idx;
        int unsigned      d;
        int unsigned      guard;
        bit               hole;
        bit               hit;
        guard = 0;
        while (count_used() != 0 && guard < 4 * N) begin
            guard++;
            s = 0;
            while (!tbl_used[s]) s++;
            k = tbl_key[s];
            fills.delete();
            do begin
                hole = 1'b0;
                hit  = 1'b0;
                for (d = 0; d < N && !hole && !hit; d++) begin
                    idx = probe_at(k, d);
                    if (!tbl_used[idx]) hole = 1'b1;
                    else if (tbl_key[idx] == k) hit = 1'b1;
                end
                if (hole) begin
                    send_op(r, ACT_INSERT, FILL_BASE | KEY_W'(idx), $urandom());
                    fills.push_back(FILL_BASE | KEY_W'(idx));
                end
            end while (hole);
            send_op(r, ACT_DELETE, k, $urandom());
            while (fills.size() != 0) send_op(r, ACT_DELETE, fills.pop_back(), $urandom());
        end
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_idle_en) begin
                m_tready <= ($urandom_range(99) >= 24);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_r.status  = m_tuser;
            got_r.slot    = m_tdata[3:0];
            got_r.probes  = m_tdata[8:4];
            got_r.payload = m_tdata[40:9];
            if (result_q.size() == 0) begin
                if (mism_cnt < 10)
                    $display("unexpected item: st=%0d slot=%0d probes=%0d pay=%h",
                             got_r.status, got_r.slot, got_r.probes, got_r.payload);
                mism_cnt++;
            end else begin
                want_r = result_q.pop_front();
                if (got_r.status !== want_r.status || got_r.slot !== want_r.slot ||
                    got_r.probes !== want_r.probes || got_r.payload !== want_r.payload) begin
                    if (mism_cnt < 10)
                        $display("mismatch: exp st=%0d slot=%0d probes=%0d pay=%h, %s%0d %0d %0d %h",
                                 want_r.status, want_r.slot, want_r.probes, want_r.payload,
                                 "got ", got_r.status, got_r.slot, got_r.probes,
                                 got_r.payload);
                    mism_cnt++;
                end
            end
        end
    end

    initial begin
        res_t             r;
        int               i;
        int               j;
        int               b;
        int               nins;
        int               mode;
        int               pick;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] tmp;
        logic [KEY_W-1:0] live [$];

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_INSERT;
        stall_req  = 1'b0;
        mism_cnt   = 0;
        items_sent = 0;

        op_tab[0]  = '{ACT_FIND, 31'h0, 1, 32'h0, 1'b1,
                       '{STATUS_NOT_FOUND, 32'h0, 5'd1, 4'd0}};
        op_tab[1]  = '{ACT_DELETE, 31'h7FFF_FFFF, 1, 32'h0, 1'b1,
                       '{STATUS_NOT_FOUND, 32'h0, 5'd1, 4'd0}};
        op_tab[2]  = '{ACT_INSERT, 31'h0, 1, 32'hFFFF_FFFF, 1'b1,
                       '{STATUS_OK, 32'h0, 5'd1, 4'd0}};
        op_tab[3]  = '{ACT_INSERT, 31'h7FFF_FFFF, 1, 32'h0, 1'b1,
                       '{STATUS_OK, 32'h0, 5'd1, 4'd15}};
        op_tab[4]  = '{ACT_FIND, 31'h0, 1, 32'h0, 1'b1,
                       '{STATUS_OK, 32'hFFFF_FFFF, 5'd1, 4'd0}};
        op_tab[5]  = '{ACT_SPARE, 31'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 1'b1,
                       '{STATUS_OK, 32'h0, 5'd1, 4'd15}};
        op_tab[6]  = '{ACT_INSERT, 31'd16, 1, 32'hAAAA_5555, 1'b0, '0};
        op_tab[7]  = '{ACT_FIND, 31'd16, 1, 32'h0, 1'b0, '0};
        op_tab[8]  = '{ACT_DELETE, 31'h0, 1, 32'h0, 1'b1,
                       '{STATUS_OK, 32'hFFFF_FFFF, 5'd1, 4'd0}};
        // chain of key 16 is now cut
        op_tab[9]  = '{ACT_FIND, 31'd16, 1, 32'h0, 1'b0, '0};
        op_tab[10] = '{ACT_DELETE, 31'h7FFF_FFFF, 1, 32'h0, 1'b1,
                       '{STATUS_OK, 32'h0, 5'd1, 4'd15}};
        // keys 0..15 fill the slots that key 16 left free, the last one runs into a full chain
        op_tab[11] = '{ACT_INSERT, 31'h0, 16, 32'h5A5A_0000, 1'b0, '0};
        op_tab[12] = '{ACT_INSERT, 31'h4000_0000, 1, 32'h1, 1'b1,
                       '{STATUS_FULL, 32'h0, 5'd15, 4'd0}};
        op_tab[13] = '{ACT_FIND, 31'h2AAA_AAAA, 1, 32'h0, 1'b1,
                       '{STATUS_NOT_FOUND, 32'h0, 5'd16, 4'd0}};
        op_tab[14] = '{ACT_SPARE, 31'h5555_5555, 1, 32'h0, 1'b0, '0};

        for (i = 0; i < POOL_N; i++) key_pool[i] = KEY_W'(($urandom() << 4) | (i % 6));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < N_ROWS; i++) begin
            for (j = 0; j < op_tab[i].reps; j++)
                send_op(r, op_tab[i].act, op_tab[i].key + KEY_W'(j), op_tab[i].pay + j,
                        op_tab[i].typed, op_tab[i].want);
        end
        drain_table();

        b = 0;
        while (items_sent < ITEM_GOAL) begin
            if (b == 15 || b == 60) stall_req = 1'b1;
            if (b == 40) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait (result_q.size() == 0);
            end
            tx_idle_en = !(b >= 80 && b < 105);
            rx_idle_en = tx_idle_en;

            nins = ($urandom_range(9) == 0) ? $urandom_range(13, 16) : $urandom_range(1, 10);
            live.delete();
            for (i = 0; i < nins; i++) begin
                k = pick_key();
                send_op(r, ACT_INSERT, k, $urandom());
                if (r.status == STATUS_OK) live.push_back(k);
                if ($urandom_range(99) < 40) send_lookup(live);
            end

            // mostly last-in first-out removal, which keeps every chain whole
            mode = $urandom_range(99);
            if (mode < 15) begin
                for (i = live.size() - 1; i > 0; i--) begin
                    pick       = $urandom_range(i);
                    tmp        = live[i];
                    live[i]    = live[pick];
                    live[pick] = tmp;
                end
            end
            if (mode < 90) begin
                for (j = live.size() - 1; j >= 0; j--) begin
                    send_op(r, ACT_DELETE, live[j], $urandom());
                    if ($urandom_range(99) < 20) send_lookup(live);
                end
            end
            if (count_used() > 10 || $urandom_range(5) == 0) drain_table();
            b++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (result_q.size() == 0);
        repeat (40) @(posedge aclk);
        if (mism_cnt == 0 && result_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- double_hash_table_engine.f -----
sv/dht_pkg.sv
sv/dht_hash.sv
sv/dht_mem.sv
sv/dht_ctrl.sv
sv/double_hash_table_engine.sv
test/tb_double_hash_table_engine.sv
